FILE: rtl/core/mts_pkg.sv
package mts_pkg;

  localparam int DATA_W      = 32;
  localparam int DEPTH_OUT_W = 7;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 80;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e_t;

  typedef struct packed {
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_load;
  } dp_stat_t;

endpackage

FILE: rtl/core/mts_datapath.sv
module mts_datapath #(
  parameter int STACK_DEPTH = 64,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mts_pkg::cmd_t                     cmd,
  output mts_pkg::dp_stat_t                 stat,
  input  logic [1:0]                        mode,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value,
  output logic signed [mts_pkg::DATA_W-1:0] top_value,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic [CW-1:0]                     count,
  output mts_pkg::status_e_t                status
);
  import mts_pkg::*;

  logic signed [DATA_W-1:0] vmem [STACK_DEPTH];
  logic signed [DATA_W-1:0] mmem [STACK_DEPTH];

  logic signed [DATA_W-1:0] top_val;
  logic signed [DATA_W-1:0] top_min;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] rd_min;
  logic signed [DATA_W-1:0] new_min;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic                     full;
  logic                     empty;
  logic                     do_push;

  assign full    = (count == CW'(STACK_DEPTH));
  assign empty   = (count == '0);
  assign do_push = cmd.exec && (mode == MODE_PUSH) && !full;
  assign new_min = (!empty && (top_min < push_value)) ? top_min : push_value;
  assign wr_addr = count[AW-1:0];
  assign rd_addr = (count >= CW'(2)) ? AW'(count - CW'(2)) : '0;

  // entry below the current top becomes the new top after a pop
  assign stat.need_load = cmd.exec && (mode == MODE_POP) && (count >= CW'(2));

  always_ff @(posedge clk) begin
    if (do_push) begin
      vmem[wr_addr] <= push_value;
      mmem[wr_addr] <= new_min;
    end
    if (stat.need_load) begin
      rd_val <= vmem[rd_addr];
      rd_min <= mmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_val <= push_value;
      top_min <= new_min;
    end else if (cmd.load) begin
      top_val <= rd_val;
      top_min <= rd_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      status <= STAT_OK;
    end else if (cmd.exec) begin
      case (mode)
        MODE_PUSH: begin
          if (full) begin
            status <= STAT_FULL;
          end else begin
            count  <= count + CW'(1);
            status <= STAT_OK;
          end
        end
        MODE_POP: begin
          if (empty) begin
            status <= STAT_EMPTY;
          end else begin
            count  <= count - CW'(1);
            status <= STAT_OK;
          end
        end
        default: begin
          status <= STAT_OK;
        end
      endcase
    end
  end

  assign top_value = empty ? '0 : top_val;
  assign min_value = empty ? '0 : top_min;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    do_push |=> (count == CW'($past(count) + CW'(1))) && (status == STAT_OK))
    else $error("push did not advance count");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (mode == MODE_POP) && empty |=> (status == STAT_EMPTY) && (count == '0))
    else $error("pop on empty stack not refused");
`endif

endmodule

FILE: rtl/core/mts_ctrl.sv
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output mts_pkg::cmd_t     cmd,
  input  mts_pkg::dp_stat_t stat
);
  import mts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SEND);
  assign cmd.exec = s_tvalid && s_tready;
  assign cmd.load = (state == ST_LOAD);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.exec) begin
          state_next = stat.need_load ? ST_LOAD : ST_SEND;
        end
      end
      ST_LOAD: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_load_to_send: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_tvalid)
    else $error("top reload not followed by result beat");

  a_exec_direct: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !stat.need_load |=> m_tvalid)
    else $error("result beat missing after accept");

  a_exec_load: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && stat.need_load |=> cmd.load && !m_tvalid)
    else $error("pop did not reload top entry");
`endif

endmodule

FILE: rtl/core/min_tracking_stack_core.sv
// LIFO stack of signed 32-bit values that also reports the minimum of all
// stored entries. Each input beat is one operation (push, pop, peek; mode 3
// acts as peek) and yields exactly one result beat with the top, the minimum,
// the entry count, an empty flag and a status code. Push on full and pop on
// empty are refused with a status and leave the stack unchanged. One item is
// in flight at a time: push and peek go from accept straight to the result
// beat, while a pop that leaves at least one entry first passes a load state
// for the registered read of the entry below the top from the on-chip stack
// memory. Top and minimum are 0 while the stack is empty. No initialization
// sweep after reset.
module min_tracking_stack_core #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [1:0] mode, [33:2] push_value, [39:34] zero
  input  logic [mts_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] top_value, [63:32] min_value, [70:64] depth_used, [71] is_empty,
  // [73:72] status, [79:74] zero
  output logic [mts_pkg::M_TDATA_W-1:0]   m_tdata
);
  import mts_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  cmd_t                     cmd;
  dp_stat_t                 stat;
  logic [1:0]               mode;
  logic signed [DATA_W-1:0] push_value;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic [CW-1:0]            count;
  status_e_t                status;
  logic [DEPTH_OUT_W-1:0]   depth_used;
  logic                     is_empty;

  assign mode       = s_tdata[1:0];
  assign push_value = s_tdata[DATA_W+1:2];

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .push_value (push_value),
    .top_value  (top_value),
    .min_value  (min_value),
    .count      (count),
    .status     (status)
  );

  assign depth_used = DEPTH_OUT_W'(count);
  assign is_empty   = (count == '0);

  assign m_tdata = {6'b0, 2'(status), is_empty, depth_used, min_value, top_value};

endmodule

FILE: tb/tb_min_tracking_stack_core.sv
module tb_min_tracking_stack_core;
  import mts_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int WD_LIMIT    = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int DUE_SLOTS   = 4;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  int quiet_cycles = 0;

  typedef struct {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] lowest;
    logic [DEPTH_OUT_W-1:0]   depth;
    logic                     empty;
    status_e_t                status;
  } stack_view_t;

  class stack_scoreboard;
    logic signed [DATA_W-1:0] values [STACK_DEPTH];
    logic signed [DATA_W-1:0] minima [STACK_DEPTH];
    int unsigned              count;
    stack_view_t              views_due [DUE_SLOTS];
    int                       due_rd;
    int                       due_wr;
    int                       due_level;
    int                       mismatches;

    function new();
      count = 0;
      due_rd = 0;
      due_wr = 0;
      due_level = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return due_level;
    endfunction

    // predict the stack view after one accepted operation
    function void note_op(logic [1:0] op, logic signed [DATA_W-1:0] v);
      stack_view_t view;
      logic signed [DATA_W-1:0] low;
      view.status = STAT_OK;
      if (op == MODE_PUSH) begin
        if (count >= STACK_DEPTH) begin
          view.status = STAT_FULL;
        end else begin
          low = v;
          if (count > 0 && minima[count-1] < v) low = minima[count-1];
          values[count] = v;
          minima[count] = low;
          count++;
        end
      end else if (op == MODE_POP) begin
        if (count == 0) view.status = STAT_EMPTY;
        else count--;
      end
      view.top    = (count > 0) ? values[count-1] : '0;
      view.lowest = (count > 0) ? minima[count-1] : '0;
      view.depth  = count[DEPTH_OUT_W-1:0];
      view.empty  = (count == 0);
      if (due_level == DUE_SLOTS) begin
        if (mismatches < 10) $display("too many result beats outstanding");
        mismatches++;
      end else begin
        views_due[due_wr] = view;
        due_wr = (due_wr + 1) % DUE_SLOTS;
        due_level++;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] beat);
      stack_view_t want;
      logic signed [DATA_W-1:0] got_top;
      logic signed [DATA_W-1:0] got_low;
      logic [DEPTH_OUT_W-1:0]   got_depth;
      logic                     got_empty;
      logic [1:0]               got_status;
      got_top    = beat[31:0];
      got_low    = beat[63:32];
      got_depth  = beat[70:64];
      got_empty  = beat[71];
      got_status = beat[73:72];
      if (due_level == 0) begin
        if (mismatches < 10) $display("unexpected result beat %h", beat);
        mismatches++;
        return;
      end
      want = views_due[due_rd];
      due_rd = (due_rd + 1) % DUE_SLOTS;
      due_level--;
      if (got_top !== want.top || got_low !== want.lowest || got_depth !== want.depth ||
          got_empty !== want.empty || got_status !== want.status) begin
        if (mismatches < 10)
          $display("mismatch: top %0d/%0d min %0d/%0d depth %0d/%0d empty %0b/%0b status %0d/%0d",
                   want.top, got_top, want.lowest, got_low, want.depth, got_depth,
                   want.empty, got_empty, want.status, got_status);
        mismatches++;
      end
    endfunction
  endclass

  stack_scoreboard sb = new();

  min_tracking_stack_core #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_op(s_tdata[1:0], s_tdata[33:2]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off each time hold_go toggles
  initial begin : rx_proc
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic drive_op(input logic [1:0] op, input logic [DATA_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(3))
      2: v = $urandom_range(8) - 4;
      3: begin
        case ($urandom_range(3))
          0: v = 32'h7fff_ffff;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // bursts lean toward filling, draining or mixing so full and empty are both hit
  task automatic random_ops(input int n);
    int lean;
    int r;
    logic [1:0] op;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) lean = $urandom_range(2);
      r = $urandom_range(99);
      case (lean)
        0: op = (r < 85) ? MODE_PUSH : (r < 95) ? MODE_POP : (r < 98) ? MODE_PEEK : MODE_SPARE;
        1: op = (r < 15) ? MODE_PUSH : (r < 90) ? MODE_POP : (r < 97) ? MODE_PEEK : MODE_SPARE;
        default:
          op = (r < 45) ? MODE_PUSH : (r < 90) ? MODE_POP : (r < 98) ? MODE_PEEK : MODE_SPARE;
      endcase
      drive_op(op, (op == MODE_PUSH || r[0]) ? pick_value() : $urandom());
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0, 0);
    drive_op(MODE_PEEK, 32'h0);
    drive_op(MODE_POP, 32'hdead_beef);
    drive_op(MODE_SPARE, 32'h1234_5678);
    drive_op(MODE_PUSH, 32'h7fff_ffff);
    drive_op(MODE_PUSH, 32'h8000_0000);
    drive_op(MODE_PUSH, 32'h8000_0000);
    drive_op(MODE_PUSH, 32'h0000_0005);
    drive_op(MODE_PEEK, 32'hffff_ffff);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_SPARE, 32'hffff_ffff);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_PUSH, 32'h0);
    drive_op(MODE_PUSH, 32'hffff_ffff);
    drive_op(MODE_PUSH, 32'h0000_0001);
    drive_op(MODE_PUSH, 32'hffff_ffff);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_PEEK, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drive_op(MODE_POP, 32'h0);
    drain();

    random_ops(420);
    // long receiver hold while the sender keeps offering
    hold_go <= ~hold_go;
    random_ops(80);
    drain();

    set_idling(67, 0);
    random_ops(400);
    drain();

    set_idling(0, 67);
    random_ops(400);
    drain();

    set_idling(9, 9);
    random_ops(430);
    drain();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
